// ----- rtl/fnvbh_pkg.sv -----
// ----------------------------------------------------------------------------
// fnvbh_pkg
// Shared widths, constants, types and the FNV-1 byte step for the bucket hash.
// ----------------------------------------------------------------------------
package fnvbh_pkg;

    localparam int HASH_W      = 64;
    localparam int BYTE_W      = 8;
    localparam int BUCKET_W    = 31;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [HASH_W-1:0]   FNV_BASIS        = 64'd2166136261;
    localparam logic [BUCKET_W-1:0] TABLE_LEN_RESET  = 31'd1024;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_HOLD
    } back_state_t;

    // h * 16777619 mod 2^64 (prime = 2^24 + 2^8 + 2^7 + 2^4 + 2^1 + 2^0), then xor byte
    function automatic logic [HASH_W-1:0] fnv_step(input logic [HASH_W-1:0] h,
                                                   input logic [BYTE_W-1:0] b);
        logic [HASH_W-1:0] prod;
        begin
            prod = (h << 24) + (h << 8) + (h << 7) + (h << 4) + (h << 1) + h;
            fnv_step = prod ^ {{(HASH_W-BYTE_W){1'b0}}, b};
        end
    endfunction

endpackage

// ----- rtl/fnvbh_front.sv -----
// ----------------------------------------------------------------------------
// fnvbh_front
// Input side: running FNV-1 hash, one byte per item (none when no_data); pushes the finished hash.
// ----------------------------------------------------------------------------
module fnvbh_front
    import fnvbh_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [BYTE_W-1:0]   data_byte,
    input  logic                last,
    input  logic                no_data,
    input  q_stat_t             q_stat,
    output logic                push,
    output logic [HASH_W-1:0]   push_hash
);

    logic [HASH_W-1:0] hash_reg;
    logic [HASH_W-1:0] hash_next;
    logic [HASH_W-1:0] hash_upd;
    logic              accept;

    assign in_stall = q_stat.full;
    assign accept   = in_valid && !in_stall;
    assign hash_upd = no_data ? hash_reg : fnv_step(hash_reg, data_byte);

    assign push      = accept && last;
    assign push_hash = hash_upd;

    always_comb
    begin
        hash_next = hash_reg;
        if (accept)
        begin
            hash_next = last ? FNV_BASIS : hash_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg <= FNV_BASIS;
        end
        else
        begin
            hash_reg <= hash_next;
        end
    end

endmodule

// ----- rtl/fnvbh_fifo.sv -----
// ----------------------------------------------------------------------------
// fnvbh_fifo
// Short queue of finished hashes between front and divider.
// ----------------------------------------------------------------------------
module fnvbh_fifo
    import fnvbh_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  logic [HASH_W-1:0]   push_hash,
    input  logic                pop,
    output logic [HASH_W-1:0]   head_hash,
    output q_stat_t             q_stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [HASH_W-1:0] mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign q_stat.full  = (count_reg == CNT_W'(DEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign head_hash    = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_hash;
        end
    end

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && q_stat.full))
        else $error("fifo: push while full");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && q_stat.empty))
        else $error("fifo: pop while empty");

endmodule

// ----- rtl/fnvbh_back.sv -----
// ----------------------------------------------------------------------------
// fnvbh_back
// Output side: bit-serial restoring modulo of the hash by table_length,
// result held in an output register.
// ----------------------------------------------------------------------------
module fnvbh_back
    import fnvbh_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [BUCKET_W-1:0]  cfg_wr_data,
    input  q_stat_t              q_stat,
    input  logic [HASH_W-1:0]    head_hash,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [BUCKET_W-1:0]  bucket
);

    localparam int CNT_W = $clog2(HASH_W);

    back_state_t         state_reg, state_next;
    logic [BUCKET_W-1:0] tlen_reg;
    logic [BUCKET_W-1:0] div_reg;
    logic [HASH_W-1:0]   quo_reg;
    logic [BUCKET_W-1:0] rem_reg, rem_next;
    logic [BUCKET_W-1:0] res_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic                out_valid_reg;
    logic [BUCKET_W-1:0] bucket_reg;

    logic [BUCKET_W:0]   trial;
    logic                last_step;
    logic                out_free;
    logic                load_out;

    assign trial     = {rem_reg, quo_reg[HASH_W-1]};
    assign rem_next  = (trial >= {1'b0, div_reg}) ? BUCKET_W'(trial - {1'b0, div_reg})
                                                  : trial[BUCKET_W-1:0];
    assign last_step = (cnt_reg == CNT_W'(HASH_W - 1));
    assign out_free  = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE: if (!q_stat.empty) state_next = BK_DIV;
            BK_DIV:  if (last_step)     state_next = BK_HOLD;
            BK_HOLD: if (out_free)      state_next = BK_IDLE;
            default: state_next = BK_IDLE;
        endcase
    end

    always_comb
    begin
        pop      = 1'b0;
        load_out = 1'b0;
        unique case (state_reg)
            BK_IDLE: pop      = !q_stat.empty;
            BK_DIV:  ;
            BK_HOLD: load_out = out_free;
            default: ;
        endcase
    end

    assign out_valid = out_valid_reg;
    assign bucket    = bucket_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            tlen_reg      <= TABLE_LEN_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                tlen_reg <= cfg_wr_data;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            quo_reg <= head_hash;
            rem_reg <= '0;
            cnt_reg <= '0;
            div_reg <= tlen_reg;
        end
        else if (state_reg == BK_DIV)
        begin
            quo_reg <= quo_reg << 1;
            rem_reg <= rem_next;
            cnt_reg <= cnt_reg + 1'b1;
            if (last_step)
            begin
                res_reg <= (div_reg == '0) ? '0 : rem_next;
            end
        end
        if (load_out)
        begin
            bucket_reg <= res_reg;
        end
    end

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (state_reg == BK_IDLE))
        else $error("back: pop outside idle");

    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        (load_out && div_reg != '0) |-> (res_reg < div_reg))
        else $error("back: remainder not below divisor");

endmodule

// ----- rtl/fnv_byte_stream_bucket_hash_core.sv -----
// ----------------------------------------------------------------------------
// fnv_byte_stream_bucket_hash_core
// FNV-1 byte-stream hash with bucket index (hash mod table_length) per string.
//
//   channel  dir  handshake            payload
//   in       in   in_valid/in_stall    data_byte, last, no_data
//   out      out  out_valid/out_stall  bucket
//   cfg      in   cfg_wr_en            cfg_wr_data (table_length)
//
// Bytes are taken one per cycle while in_stall is low; the hash update is a single constant multiply.
// Each string end passes through the serial divider (one bit/cycle), which works on one hash at a time.
// A queue of QUEUE_DEPTH hashes lets bytes flow while the divider is busy.
// in_stall rises only when the queue is full.
// Reset: hash to offset basis, table_length to 1024, queue empty.
// ----------------------------------------------------------------------------
module fnv_byte_stream_bucket_hash_core
    import fnvbh_pkg::*;
#(
    parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [BUCKET_W-1:0]  cfg_wr_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [BYTE_W-1:0]    data_byte,
    input  logic                 last,
    input  logic                 no_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [BUCKET_W-1:0]  bucket
);

    q_stat_t           q_stat;
    logic              push;
    logic [HASH_W-1:0] push_hash;
    logic              pop;
    logic [HASH_W-1:0] head_hash;

    fnvbh_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .data_byte (data_byte),
        .last      (last),
        .no_data   (no_data),
        .q_stat    (q_stat),
        .push      (push),
        .push_hash (push_hash)
    );

    fnvbh_fifo #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_hash (push_hash),
        .pop       (pop),
        .head_hash (head_hash),
        .q_stat    (q_stat)
    );

    fnvbh_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .q_stat      (q_stat),
        .head_hash   (head_hash),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .bucket      (bucket)
    );

endmodule
